// ----- design/rbcw_pkg.sv -----
// Shared types and constants for the ROI beam centroid/width block.
// No dependencies; imported by the divide / root unit and the top level.
package rbcw_pkg;

    // Sum and result widths
    localparam int W_SUM  = 40;
    localparam int W_XY   = 52;
    localparam int W_SQ   = 63;
    localparam int W_WIDE = 128;
    localparam int W_Q    = 39;
    localparam int W_RES  = 19;

    localparam logic [W_RES-1:0] SIG_MAX = '1;

    // Iteration counts of the divide / root unit (count is iterations minus one)
    localparam logic [5:0] CEN_STEPS  = 6'd19;
    localparam logic [5:0] SIG_STEPS  = 6'd38;
    localparam logic [5:0] SQRT_STEPS = 6'd18;
    localparam int         SQRT_BIT0  = 36;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ROW_A     = 3'd0,
        CFG_ROW_B     = 3'd1,
        CFG_COL_A     = 3'd2,
        CFG_COL_B     = 3'd3,
        CFG_OFFSET    = 3'd4,
        CFG_USE_CORR  = 3'd5
    } t_cfg_idx;

    // Main sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PX,
        ST_PY,
        ST_PXX,
        ST_PYY,
        ST_PACC,
        ST_POST,
        ST_CEN,
        ST_CWAIT,
        ST_SIG,
        ST_SA,
        ST_SB,
        ST_SD,
        ST_SWAIT,
        ST_QWAIT,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef enum logic {
        DS_DIV,
        DS_SQRT
    } t_ds_mode;

    // Request into the divide / root unit
    typedef struct packed {
        logic       start;
        t_ds_mode   mode;
        logic [5:0] steps;
    } t_ds_req;

    // Status back from the divide / root unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_ds_sts;

endpackage

// ----- design/rbcw_mul.sv -----
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on nothing outside this file.
module rbcw_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    // one partial product per cycle
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ----- design/rbcw_divsqrt.sv -----
// Shift-subtract unit: restoring division one quotient bit per cycle, or
// integer square root two radicand bits per cycle. Depends on rbcw_pkg.
module rbcw_divsqrt (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rbcw_pkg::t_ds_req      i_req,
    input  logic [127:0]           i_num,
    input  logic [127:0]           i_den,
    output rbcw_pkg::t_ds_sts      o_sts,
    output logic [38:0]            o_quot
);
    import rbcw_pkg::*;

    logic [W_WIDE-1:0] r_rem;
    logic [W_WIDE-1:0] r_dd;
    logic [W_Q-1:0]    r_q;
    logic [5:0]        r_cnt;
    t_ds_mode          r_mode;
    logic              r_busy;
    logic              r_done;

    logic [W_WIDE-1:0] w_b;
    logic [W_WIDE:0]   w_diff;
    logic              w_ge;

    // one shared compare/subtract; root mode subtracts root + bit
    always_comb begin
        if (r_mode == DS_SQRT) begin
            w_b = {{(W_WIDE-W_Q){1'b0}}, r_dd[W_Q-1:0] + r_q};
        end else begin
            w_b = r_dd;
        end
        w_diff = {1'b0, r_rem} - {1'b0, w_b};
        w_ge   = ~w_diff[W_WIDE];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mode <= i_req.mode;
            r_cnt  <= i_req.steps;
            r_rem  <= i_num;
            r_q    <= '0;
            if (i_req.mode == DS_SQRT) begin
                r_dd <= W_WIDE'(1) << SQRT_BIT0;
            end else begin
                r_dd <= i_den;
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (w_ge) begin
                r_rem <= w_diff[W_WIDE-1:0];
            end
            if (r_mode == DS_DIV) begin
                r_q  <= {r_q[W_Q-2:0], w_ge};
                r_dd <= r_dd >> 1;
            end else begin
                r_q  <= w_ge ? ((r_q >> 1) + r_dd[W_Q-1:0]) : (r_q >> 1);
                r_dd <= r_dd >> 2;
            end
        end
    end

    assign o_sts  = '{busy: r_busy, done: r_done};
    assign o_quot = r_q;

endmodule

// ----- design/roi_beam_centroid_width.sv -----
// Top level: ROI beam centroid and RMS width. A pixel steps through PX, PY, PXX,
// PYY and PACC before ready returns (four passes through the one 32x32 multiplier).
// A frame_end pixel then starts the result work, which uses the multiplier doing
// 64x64 products in four partial products and the 1-bit per cycle divide/root
// unit. A finished result waits in an output register.
// Synchronous active-low reset clears sums, config and handshakes.
module roi_beam_centroid_width #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int PIXEL_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // raw_pixel[15:0], corrected_pixel[31:16], column[42:32], row[53:43]
    input  logic [55:0]  i_s_axis_tdata,
    input  logic         i_s_axis_tlast,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // centroid_x[18:0], centroid_y[37:19], sigma_x[56:38], sigma_y[75:57],
    // total_intensity[114:76]
    output logic [119:0] o_m_axis_tdata,
    // valid_res[0]
    output logic         o_m_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_data
);
    import rbcw_pkg::*;

    localparam logic [15:0] PIX_MASK = 16'((32'd1 << PIXEL_BITS) - 32'd1);

    t_state r_state, n_state;

    // configuration
    logic [10:0] r_row_a, r_row_b, r_col_a, r_col_b;
    logic [15:0] r_offset;
    logic        r_use_corr;

    // pixel pipeline registers
    logic        r_neg, r_inroi, r_last;
    logic [15:0] r_mag;
    logic [10:0] r_x, r_y;
    logic [26:0] r_mx, r_my;
    logic [37:0] r_mxx;

    // running sums
    logic [W_SUM-1:0] r_s;
    logic [W_XY-1:0]  r_sx, r_sy;
    logic [W_SQ-1:0]  r_sxx, r_syy;

    // end-of-frame work
    logic              r_ax;
    logic [W_RES-1:0]  r_cen [2];
    logic [W_RES-1:0]  r_sig [2];
    logic [38:0]       r_tot;
    logic              r_vld;
    logic [W_WIDE-1:0] r_a, r_acc;
    logic [63:0]       r_ma, r_mb;
    logic [1:0]        r_pp;
    logic              r_ph;
    t_state            r_ret;

    // output register
    logic              r_ovalid;
    logic [W_RES-1:0]  r_o_cx, r_o_cy, r_o_sx, r_o_sy;
    logic [38:0]       r_o_tot;
    logic              r_o_vld;

    logic w_in_acc, w_out_acc;

    // ---------------- pixel front end ----------------
    logic [15:0] w_pix;
    logic [16:0] w_p, w_pneg;
    logic [10:0] w_x, w_y, w_rlo, w_rhi, w_clo, w_chi;
    logic        w_inroi;

    always_comb begin
        w_pix  = (r_use_corr ? i_s_axis_tdata[31:16] : i_s_axis_tdata[15:0]) & PIX_MASK;
        w_p    = {1'b0, w_pix} - {1'b0, r_offset};
        w_pneg = ~w_p + 17'd1;
        w_x    = i_s_axis_tdata[42:32];
        w_y    = i_s_axis_tdata[53:43];
        w_rlo  = (r_row_a < r_row_b) ? r_row_a : r_row_b;
        w_rhi  = (r_row_a < r_row_b) ? r_row_b : r_row_a;
        w_clo  = (r_col_a < r_col_b) ? r_col_a : r_col_b;
        w_chi  = (r_col_a < r_col_b) ? r_col_b : r_col_a;
        w_inroi = (w_x >= w_clo) && (w_x <= w_chi) && (w_y >= w_rlo) && (w_y <= w_rhi)
                && ({21'd0, w_x} < 32'(MAX_WIDTH)) && ({21'd0, w_y} < 32'(MAX_HEIGHT));
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc       = r_ovalid && i_m_axis_tready;

    // ---------------- shared multiplier ----------------
    logic [31:0] w_mul_a, w_mul_b;
    logic [63:0] w_prod;
    logic [W_WIDE-1:0] w_pp_sh;
    logic [1:0]  w_pp_pos;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_PX: begin
                w_mul_a = {16'd0, r_mag};
                w_mul_b = {21'd0, r_x};
            end
            ST_PY: begin
                w_mul_a = {16'd0, r_mag};
                w_mul_b = {21'd0, r_y};
            end
            ST_PXX: begin
                w_mul_a = {5'd0, r_mx};
                w_mul_b = {21'd0, r_x};
            end
            ST_PYY: begin
                w_mul_a = {5'd0, r_my};
                w_mul_b = {21'd0, r_y};
            end
            ST_MUL: begin
                w_mul_a = r_pp[1] ? r_ma[63:32] : r_ma[31:0];
                w_mul_b = r_pp[0] ? r_mb[63:32] : r_mb[31:0];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_pp_pos = {1'b0, r_pp[1]} + {1'b0, r_pp[0]};
        case (w_pp_pos)
            2'd0:    w_pp_sh = {64'd0, w_prod};
            2'd1:    w_pp_sh = {32'd0, w_prod, 32'd0};
            default: w_pp_sh = {w_prod, 64'd0};
        endcase
    end

    rbcw_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // ---------------- signed accumulation terms ----------------
    logic [W_SUM-1:0] w_t_s;
    logic [W_XY-1:0]  w_t_x, w_t_y;
    logic [W_SQ-1:0]  w_t_xx, w_t_yy;

    always_comb begin
        w_t_s  = W_SUM'(r_mag);
        w_t_x  = W_XY'(r_mx);
        w_t_y  = W_XY'(r_my);
        w_t_xx = W_SQ'(r_mxx);
        w_t_yy = W_SQ'(w_prod[37:0]);
        if (r_neg) begin
            w_t_s  = ~w_t_s + 1'b1;
            w_t_x  = ~w_t_x + 1'b1;
            w_t_y  = ~w_t_y + 1'b1;
            w_t_xx = ~w_t_xx + 1'b1;
            w_t_yy = ~w_t_yy + 1'b1;
        end
    end

    // ---------------- end-of-frame operands ----------------
    logic              w_s_pos, w_sx_pos, w_sxx_pos;
    logic [W_XY-1:0]   w_sx_sel, w_ax_abs;
    logic [W_SQ-1:0]   w_sxx_sel;
    logic [59:0]       w_cnum;
    logic [38:0]       w_tot;

    always_comb begin
        w_s_pos   = !r_s[W_SUM-1] && (r_s != '0);
        w_sx_sel  = r_ax ? r_sy : r_sx;
        w_sxx_sel = r_ax ? r_syy : r_sxx;
        w_sx_pos  = !w_sx_sel[W_XY-1] && (w_sx_sel != '0);
        w_sxx_pos = !w_sxx_sel[W_SQ-1] && (w_sxx_sel != '0);
        w_ax_abs  = w_sx_sel[W_XY-1] ? (~w_sx_sel + 1'b1) : w_sx_sel;
        // sx*256 + s/2, rounding the centroid to nearest
        w_cnum    = {1'b0, w_sx_sel[50:0], 8'd0} + {22'd0, r_s[38:1]};
        if (r_s[39] != r_s[38]) begin
            w_tot = r_s[39] ? {1'b1, 38'd0} : {1'b0, {38{1'b1}}};
        end else begin
            w_tot = r_s[38:0];
        end
    end

    // ---------------- divide / root unit ----------------
    t_ds_req           ds_req;
    t_ds_sts           ds_sts;
    logic [W_WIDE-1:0] w_ds_num, w_ds_den;
    logic [38:0]       ds_q;

    rbcw_divsqrt u_ds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ds_req),
        .i_num   (w_ds_num),
        .i_den   (w_ds_den),
        .o_sts   (ds_sts),
        .o_quot  (ds_q)
    );

    // ---------------- sequencer: next state and controls ----------------
    logic             w_wr_cen, w_wr_sig, w_adv, w_load, w_mstart;
    logic [W_RES-1:0] w_res;
    logic [63:0]      w_ma, w_mb;
    t_state           w_mret;

    always_comb begin
        n_state  = r_state;
        ds_req   = '{start: 1'b0, mode: DS_DIV, steps: '0};
        w_ds_num = '0;
        w_ds_den = '0;
        w_wr_cen = 1'b0;
        w_wr_sig = 1'b0;
        w_adv    = 1'b0;
        w_load   = 1'b0;
        w_mstart = 1'b0;
        w_res    = '0;
        w_ma     = '0;
        w_mb     = '0;
        w_mret   = ST_IDLE;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_PX;
                end
            end
            ST_PX:   n_state = ST_PY;
            ST_PY:   n_state = ST_PXX;
            ST_PXX:  n_state = ST_PYY;
            ST_PYY:  n_state = ST_PACC;
            ST_PACC: n_state = r_last ? ST_POST : ST_IDLE;
            ST_POST: n_state = w_s_pos ? ST_CEN : ST_OUT;
            ST_CEN: begin
                if (!w_sx_pos) begin
                    w_wr_cen = 1'b1;
                    w_adv    = 1'b1;
                    n_state  = r_ax ? ST_SIG : ST_CEN;
                end else begin
                    ds_req   = '{start: 1'b1, mode: DS_DIV, steps: CEN_STEPS};
                    w_ds_num = {68'd0, w_cnum};
                    w_ds_den = {70'd0, r_s[38:0], 19'd0};
                    n_state  = ST_CWAIT;
                end
            end
            ST_CWAIT: begin
                if (ds_sts.done) begin
                    w_wr_cen = 1'b1;
                    w_res    = ds_q[19] ? SIG_MAX : ds_q[18:0];
                    w_adv    = 1'b1;
                    n_state  = r_ax ? ST_SIG : ST_CEN;
                end
            end
            ST_SIG: begin
                if (!w_sxx_pos) begin
                    w_wr_sig = 1'b1;
                    w_adv    = 1'b1;
                    n_state  = r_ax ? ST_OUT : ST_SIG;
                end else begin
                    // S * Sxx
                    w_mstart = 1'b1;
                    w_ma     = {1'b0, w_sxx_sel};
                    w_mb     = {24'd0, r_s};
                    w_mret   = ST_SA;
                    n_state  = ST_MUL;
                end
            end
            ST_SA: begin
                // Sx * Sx
                w_mstart = 1'b1;
                w_ma     = {12'd0, w_ax_abs};
                w_mb     = {12'd0, w_ax_abs};
                w_mret   = ST_SB;
                n_state  = ST_MUL;
            end
            ST_SB: begin
                if (r_acc >= r_a) begin
                    w_wr_sig = 1'b1;
                    w_adv    = 1'b1;
                    n_state  = r_ax ? ST_OUT : ST_SIG;
                end else begin
                    // S * S
                    w_mstart = 1'b1;
                    w_ma     = {24'd0, r_s};
                    w_mb     = {24'd0, r_s};
                    w_mret   = ST_SD;
                    n_state  = ST_MUL;
                end
            end
            ST_SD: begin
                ds_req   = '{start: 1'b1, mode: DS_DIV, steps: SIG_STEPS};
                w_ds_num = r_a;
                w_ds_den = {r_acc[89:0], 38'd0};
                n_state  = ST_SWAIT;
            end
            ST_SWAIT: begin
                if (ds_sts.done) begin
                    if (ds_q[38]) begin
                        w_wr_sig = 1'b1;
                        w_res    = SIG_MAX;
                        w_adv    = 1'b1;
                        n_state  = r_ax ? ST_OUT : ST_SIG;
                    end else begin
                        ds_req   = '{start: 1'b1, mode: DS_SQRT, steps: SQRT_STEPS};
                        w_ds_num = {90'd0, ds_q[37:0]};
                        n_state  = ST_QWAIT;
                    end
                end
            end
            ST_QWAIT: begin
                if (ds_sts.done) begin
                    w_wr_sig = 1'b1;
                    w_res    = ds_q[18:0];
                    w_adv    = 1'b1;
                    n_state  = r_ax ? ST_OUT : ST_SIG;
                end
            end
            ST_MUL: begin
                if (r_ph && r_pp == 2'd3) begin
                    n_state = r_ret;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || w_out_acc) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_row_a    <= 11'd0;
            r_row_b    <= 11'd2047;
            r_col_a    <= 11'd0;
            r_col_b    <= 11'd2047;
            r_offset   <= 16'd0;
            r_use_corr <= 1'b0;
            r_s        <= '0;
            r_sx       <= '0;
            r_sy       <= '0;
            r_sxx      <= '0;
            r_syy      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;

            // register writes
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_ROW_A:    r_row_a    <= i_cfg_data[10:0];
                    CFG_ROW_B:    r_row_b    <= i_cfg_data[10:0];
                    CFG_COL_A:    r_col_a    <= i_cfg_data[10:0];
                    CFG_COL_B:    r_col_b    <= i_cfg_data[10:0];
                    CFG_OFFSET:   r_offset   <= i_cfg_data;
                    CFG_USE_CORR: r_use_corr <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // accumulate, clear once the result is loaded into the output register
            if (r_state == ST_PACC && r_inroi) begin
                r_s   <= r_s + w_t_s;
                r_sx  <= r_sx + w_t_x;
                r_sy  <= r_sy + w_t_y;
                r_sxx <= r_sxx + w_t_xx;
                r_syy <= r_syy + w_t_yy;
            end else if (w_load) begin
                r_s   <= '0;
                r_sx  <= '0;
                r_sy  <= '0;
                r_sxx <= '0;
                r_syy <= '0;
            end

            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (w_out_acc) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        // capture pixel request
        if (w_in_acc) begin
            r_neg   <= w_p[16];
            r_mag   <= w_p[16] ? w_pneg[15:0] : w_p[15:0];
            r_x     <= w_x;
            r_y     <= w_y;
            r_inroi <= w_inroi;
            r_last  <= i_s_axis_tlast;
        end

        case (r_state)
            ST_PY:   r_mx  <= w_prod[26:0];
            ST_PXX:  r_my  <= w_prod[26:0];
            ST_PYY:  r_mxx <= w_prod[37:0];
            ST_SA:   r_a   <= r_acc;
            ST_SB:   r_a   <= (r_a - r_acc) << 16;
            ST_POST: begin
                r_tot    <= w_tot;
                r_vld    <= w_s_pos;
                r_ax     <= 1'b0;
                r_cen[0] <= '0;
                r_cen[1] <= '0;
                r_sig[0] <= '0;
                r_sig[1] <= '0;
            end
            default: ;
        endcase

        // wide product: four partial products, issue then add
        if (w_mstart) begin
            r_ma  <= w_ma;
            r_mb  <= w_mb;
            r_acc <= '0;
            r_pp  <= 2'd0;
            r_ph  <= 1'b0;
            r_ret <= w_mret;
        end else if (r_state == ST_MUL) begin
            r_ph <= ~r_ph;
            if (r_ph) begin
                r_acc <= r_acc + w_pp_sh;
                r_pp  <= r_pp + 2'd1;
            end
        end

        if (w_wr_cen) begin
            r_cen[r_ax] <= w_res;
        end
        if (w_wr_sig) begin
            r_sig[r_ax] <= w_res;
        end
        if (w_adv) begin
            r_ax <= ~r_ax;
        end

        if (w_load) begin
            r_o_cx  <= r_cen[0];
            r_o_cy  <= r_cen[1];
            r_o_sx  <= r_sig[0];
            r_o_sy  <= r_sig[1];
            r_o_tot <= r_tot;
            r_o_vld <= r_vld;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {5'd0, r_o_tot, r_o_sy, r_o_sx, r_o_cy, r_o_cx};
    assign o_m_axis_tuser  = r_o_vld;

    // ---------------- assertions ----------------
    a_ready_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !ds_sts.busy)
        else $error("pixel request taken while divide/root unit busy");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ds_sts.done |-> (r_state == ST_CWAIT || r_state == ST_SWAIT || r_state == ST_QWAIT))
        else $error("divide/root result arrived outside a wait state");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_o_vld) |->
        (r_o_cx == '0 && r_o_cy == '0 && r_o_sx == '0 && r_o_sy == '0))
        else $error("moments nonzero on a result with no positive total");

    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_s == '0 && r_sx == '0 && r_sy == '0 && r_sxx == '0 && r_syy == '0))
        else $error("sums not cleared after frame result");

endmodule

// ----- test/roi_beam_centroid_width_chk.sv -----
// Checker for roi_beam_centroid_width: watches pixel and result channels,
// predicts frame results and compares them. Depends on rbcw_pkg.
module roi_beam_centroid_width_chk
    import rbcw_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [55:0]  i_pix_data,
    input  logic         i_pix_last,
    input  logic         i_pix_valid,
    input  logic         i_pix_ready,
    input  logic [119:0] i_res_data,
    input  logic         i_res_user,
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [18:0] cen_x;
        logic [18:0] cen_y;
        logic [18:0] sig_x;
        logic [18:0] sig_y;
        logic [38:0] total;
        logic        valid;
    } t_frame_res;

    t_frame_res frame_q[$];

    // Model copy of registers and sums
    logic [10:0] row_a, row_b, col_a, col_b;
    logic [15:0] black_lvl;
    logic        sel_corr;
    logic [39:0] acc_s;
    logic [51:0] acc_x, acc_y;
    logic [62:0] acc_xx, acc_yy;

    assign o_pending = frame_q.size();

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    function automatic logic [18:0] centroid_q8(input longint sx, input longint s);
        longint q;
        if (sx <= 0) return 0;
        q = (sx * 256 + s / 2) / s;
        return (q > 524287) ? 19'h7FFFF : q[18:0];
    endfunction

    function automatic logic [18:0] rms_width(input longint sxx, input longint sx,
                                              input longint s);
        logic [127:0] a, b, num, d;
        logic [63:0]  q, r, bt, v;
        if (sxx <= 0) return 0;
        a = 128'(sxx) * 128'(s);
        b = 128'(sx < 0 ? -sx : sx) * 128'(sx < 0 ? -sx : sx);
        if (b >= a) return 0;
        num = (a - b) << 16;
        d = 128'(s) * 128'(s);
        if (num >= (d << 38)) return 19'h7FFFF;
        q = 64'(num / d);
        // integer floor square root
        v = q; r = 0; bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v -= r + bt;
                r = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        return (r > 524287) ? 19'h7FFFF : r[18:0];
    endfunction

    always @(posedge i_clk) begin
        logic [15:0] pix;
        logic [10:0] x, y, rlo, rhi, clo, chi;
        longint p, s, sx, sy, tot;
        t_frame_res e, g;
        if (!i_rst_n) begin
            row_a <= 0; row_b <= 11'd2047; col_a <= 0; col_b <= 11'd2047;
            black_lvl <= 0; sel_corr <= 0;
            acc_s = 0; acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0;
            frame_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_ROW_A:    row_a <= i_cfg_data[10:0];
                    CFG_ROW_B:    row_b <= i_cfg_data[10:0];
                    CFG_COL_A:    col_a <= i_cfg_data[10:0];
                    CFG_COL_B:    col_b <= i_cfg_data[10:0];
                    CFG_OFFSET:   black_lvl <= i_cfg_data;
                    CFG_USE_CORR: sel_corr <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // Pixel request: accumulate, and predict on frame end
            if (i_pix_valid && i_pix_ready) begin
                pix = sel_corr ? i_pix_data[31:16] : i_pix_data[15:0];
                x = i_pix_data[42:32];
                y = i_pix_data[53:43];
                rlo = (row_a < row_b) ? row_a : row_b;
                rhi = (row_a < row_b) ? row_b : row_a;
                clo = (col_a < col_b) ? col_a : col_b;
                chi = (col_a < col_b) ? col_b : col_a;
                if (x >= clo && x <= chi && y >= rlo && y <= rhi) begin
                    p = longint'(pix) - longint'(black_lvl);
                    acc_s  = acc_s + 40'(p);
                    acc_x  = acc_x + 52'(p * x);
                    acc_y  = acc_y + 52'(p * y);
                    acc_xx = acc_xx + 63'(p * x * x);
                    acc_yy = acc_yy + 63'(p * y * y);
                end
                if (i_pix_last) begin
                    s  = longint'($signed(acc_s));
                    sx = longint'($signed(acc_x));
                    sy = longint'($signed(acc_y));
                    tot = s;
                    if (tot > (64'sd1 <<< 38) - 1) tot = (64'sd1 <<< 38) - 1;
                    if (tot < -(64'sd1 <<< 38)) tot = -(64'sd1 <<< 38);
                    e = '0;
                    e.total = tot[38:0];
                    if (s > 0) begin
                        e.cen_x = centroid_q8(sx, s);
                        e.cen_y = centroid_q8(sy, s);
                        e.sig_x = rms_width(longint'($signed(acc_xx)), sx, s);
                        e.sig_y = rms_width(longint'($signed(acc_yy)), sy, s);
                        e.valid = 1'b1;
                    end
                    frame_q.push_back(e);
                    acc_s = 0; acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0;
                end
            end
            // Result request: compare with oldest prediction
            if (i_res_valid && i_res_ready) begin
                g.cen_x = i_res_data[18:0];
                g.cen_y = i_res_data[37:19];
                g.sig_x = i_res_data[56:38];
                g.sig_y = i_res_data[75:57];
                g.total = i_res_data[114:76];
                g.valid = i_res_user;
                if (frame_q.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    e = frame_q.pop_front();
                    if (g.cen_x != e.cen_x) report_mismatch("centroid_x", g.cen_x, e.cen_x);
                    if (g.cen_y != e.cen_y) report_mismatch("centroid_y", g.cen_y, e.cen_y);
                    if (g.sig_x != e.sig_x) report_mismatch("sigma_x", g.sig_x, e.sig_x);
                    if (g.sig_y != e.sig_y) report_mismatch("sigma_y", g.sig_y, e.sig_y);
                    if (g.total != e.total) report_mismatch("total", g.total, e.total);
                    if (g.valid != e.valid) report_mismatch("valid_res", g.valid, e.valid);
                end
            end
        end
    end

endmodule

// ----- test/roi_beam_centroid_width_tb.sv -----
// Testbench top for roi_beam_centroid_width: drives pixels, register writes
// and output stalls; verdict from roi_beam_centroid_width_chk.
module roi_beam_centroid_width_tb;
    import rbcw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic [55:0]  s_data = '0;
    logic         s_last = 0, s_valid = 0, s_ready;
    logic [119:0] m_data;
    logic         m_user, m_valid, m_ready = 0;
    logic         cfg_we = 0;
    logic [2:0]   cfg_addr = '0;
    logic [15:0]  cfg_data = '0;
    int           fail_count, pending;
    int           idle_cycles = 0;
    bit           hold_off = 0;

    always #10 i_clk = ~i_clk;

    roi_beam_centroid_width DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tdata(s_data), .i_s_axis_tlast(s_last),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data)
    );

    roi_beam_centroid_width_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_pix_data(s_data), .i_pix_last(s_last),
        .i_pix_valid(s_valid), .i_pix_ready(s_ready),
        .i_res_data(m_data), .i_res_user(m_user),
        .i_res_valid(m_valid), .i_res_ready(m_ready),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Result side stall pattern, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    // Watchdog: cycles without any request
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("roi_beam_centroid_width_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_region(input logic [10:0] ra, rb, ca, cb);
        write_reg(CFG_ROW_A, 16'(ra));
        write_reg(CFG_ROW_B, 16'(rb));
        write_reg(CFG_COL_A, 16'(ca));
        write_reg(CFG_COL_B, 16'(cb));
    endtask

    // One pixel request; called at a falling edge, returns at a falling edge
    task automatic send_pixel(input logic [15:0] raw, corr, input logic [10:0] col, row,
                              input logic last);
        s_data <= {2'b00, row, col, corr, raw};
        s_last <= last;
        s_valid <= 1'b1;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drop_valid();
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        drop_valid();
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    // Frame of random pixels, near a spot if spot is set; gaps between bursts
    task automatic random_frame(input int npix, input bit spot);
        logic [10:0] cx, cy;
        cx = 11'($urandom_range(0, 2047));
        cy = 11'($urandom_range(0, 2047));
        for (int k = 0; k < npix; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                drop_valid();
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            if (spot)
                send_pixel(16'($urandom), 16'($urandom), cx + 11'($urandom_range(0, 6)),
                           cy + 11'($urandom_range(0, 6)), k == npix - 1);
            else
                send_pixel(16'($urandom), 16'($urandom), 11'($urandom), 11'($urandom),
                           k == npix - 1);
        end
    endtask

    initial begin
        int sent;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: defaults, extremes, single pixel frames
        send_pixel(16'hFFFF, 16'h0000, 11'd2047, 11'd2047, 1'b1);
        send_pixel(16'h0000, 16'hFFFF, 11'd0, 11'd0, 1'b1);
        send_pixel(16'h8000, 16'h1234, 11'd0, 11'd2047, 1'b0);
        send_pixel(16'h8000, 16'h1234, 11'd2047, 11'd0, 1'b1);
        send_pixel(16'h5555, 16'hAAAA, 11'h555, 11'h2AA, 1'b0);
        send_pixel(16'hAAAA, 16'h5555, 11'h2AA, 11'h555, 1'b1);
        wait_drained();
        // negative total: offset above pixels, corrected source
        write_reg(CFG_OFFSET, 16'hFFFF);
        write_reg(CFG_USE_CORR, 16'h0001);
        send_pixel(16'hFFFF, 16'h0010, 11'd5, 11'd6, 1'b0);
        send_pixel(16'hFFFF, 16'h0000, 11'd7, 11'd8, 1'b1);
        wait_drained();
        // negative pixel with positive total, reversed region edges
        write_reg(CFG_OFFSET, 16'd1000);
        write_region(11'd100, 11'd10, 11'd300, 11'd20);
        send_pixel(16'd0, 16'd0, 11'd200, 11'd50, 1'b0);
        send_pixel(16'd0, 16'd60000, 11'd20, 11'd50, 1'b0);
        send_pixel(16'd0, 16'd5000, 11'd19, 11'd50, 1'b0);
        send_pixel(16'd0, 16'd5000, 11'd20, 11'd101, 1'b1);
        // zero variance: one pixel inside
        send_pixel(16'd0, 16'd3000, 11'd300, 11'd100, 1'b1);
        send_pixel(16'd0, 16'd0, 11'd0, 11'd0, 1'b1);
        wait_drained();
        write_region(11'd5, 11'd5, 11'd2047, 11'd2047);
        write_reg(CFG_OFFSET, 16'd0);
        write_reg(CFG_USE_CORR, 16'd0);
        send_pixel(16'hFFFF, 16'd0, 11'd2047, 11'd5, 1'b0);
        send_pixel(16'hFFFF, 16'd0, 11'd2046, 11'd5, 1'b1);
        wait_drained();

        // Output hold-off while pixels keep coming
        hold_off = 1;
        write_region(11'd0, 11'd2047, 11'd0, 11'd2047);
        fork
            begin
                repeat (600) @(negedge i_clk);
                hold_off = 0;
            end
            for (int f = 0; f < 4; f++) random_frame(3, 1'b1);
        join
        wait_drained();

        // Random phases with different register settings
        sent = 0;
        while (sent < 410) begin
            int np;
            if ($urandom_range(0, 2) == 0) begin
                write_region(11'($urandom), 11'($urandom), 11'($urandom), 11'($urandom));
            end else begin
                logic [10:0] r0, c0;
                r0 = 11'($urandom_range(0, 2030));
                c0 = 11'($urandom_range(0, 2030));
                write_region(r0, r0 + 11'($urandom_range(0, 15)),
                             c0 + 11'($urandom_range(0, 15)), c0);
            end
            write_reg(CFG_OFFSET, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(0, 300)));
            write_reg(CFG_USE_CORR, 16'($urandom_range(0, 1)));
            for (int f = 0; f < 6; f++) begin
                np = $urandom_range(1, 12);
                random_frame(np, $urandom_range(0, 4) != 0);
                sent += np;
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("roi_beam_centroid_width_tb OK");
        else
            $display("roi_beam_centroid_width_tb NOT OK");
        $finish;
    end
endmodule
